>>> hw/rtl/point_mass_force_generator_assert.svh
// Assertion macros for the point mass force generator.
`ifndef POINT_MASS_FORCE_GENERATOR_ASSERT_SVH
`define POINT_MASS_FORCE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PMFG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define PMFG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PMFG_ASSERT_IMP(lbl, ante, cons)
`define PMFG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/pmfg_pkg.sv
// Shared types and constants of the point mass force generator.
package pmfg_pkg;
	localparam int MagW = 33;
	localparam int SumW = 70;
	localparam int LenW = 35;
	localparam int NumW = 51;
	localparam int FacW = 48;
	localparam int CfgW = 31;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	localparam logic [FacW-1:0] FacCap = 48'h8000_0000_0000;

	typedef enum logic [1:0] {
		OP_DRAG,
		OP_SPRING,
		OP_BUNGEE,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		REG_DRAG_LIN,
		REG_DRAG_QUAD,
		REG_SPR_K,
		REG_SPR_REST,
		REG_BNG_K,
		REG_BNG_REST
	} reg_idx_t;

	typedef struct packed {
		op_t op;
		logic [2:0] pos;
		logic [2:0][MagW-1:0] mag;
	} pmfg_item_t;

	typedef struct packed {
		pmfg_item_t item;
		logic zero;
		logic [65:0] dprod;
	} pmfg_side_t;

	typedef struct packed {
		logic [CfgW-1:0] drag_lin;
		logic [CfgW-1:0] drag_quad;
		logic [CfgW-1:0] spr_k;
		logic [CfgW-1:0] spr_rest;
		logic [CfgW-1:0] bng_k;
		logic [CfgW-1:0] bng_rest;
	} pmfg_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pmfg_qstat_t;
endpackage

>>> hw/rtl/pmfg_front.sv
// Front end: takes input transfers and forms difference magnitudes and signs.
module pmfg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic q_full,
	output logic item_valid,
	output pmfg_pkg::pmfg_item_t item
);
	logic f_valid_s1;
	pmfg_pkg::pmfg_item_t f_item_s1;
	pmfg_pkg::pmfg_item_t nxt;
	logic [2:0][31:0] av;
	logic [2:0][31:0] bv;

	assign av = {a_z, a_y, a_x};
	assign bv = {b_z, b_y, b_x};

	always_comb begin
		logic [32:0] w;
		nxt.op = pmfg_pkg::op_t'(operation);
		for (int i = 0; i < 3; i++) begin
			if (pmfg_pkg::op_t'(operation) == pmfg_pkg::OP_DRAG) begin
				w = {av[i][31], av[i]};
			end else begin
				w = {av[i][31], av[i]} - {bv[i][31], bv[i]};
			end
			nxt.mag[i] = w[32] ? 33'(0 - w) : w;
			nxt.pos[i] = !w[32] && (w != 33'd0);
		end
	end

	assign in_stall = f_valid_s1 && q_full;
	assign item_valid = f_valid_s1;
	assign item = f_item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			f_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			f_item_s1 <= nxt;
		end
	end
endmodule

>>> hw/rtl/pmfg_queue.sv
// Short queue between the front end and the arithmetic pipeline.
module pmfg_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pmfg_pkg::pmfg_item_t push_item,
	input  logic pop,
	output pmfg_pkg::pmfg_item_t head,
	output pmfg_pkg::pmfg_qstat_t stat
);
	pmfg_pkg::pmfg_item_t mem_q [pmfg_pkg::QDepth];
	logic [pmfg_pkg::QPtrW-1:0] wr_q;
	logic [pmfg_pkg::QPtrW-1:0] rd_q;
	logic [pmfg_pkg::QPtrW:0] count_q;
	logic do_push;
	logic do_pop;

	assign stat.full = (count_q == (pmfg_pkg::QPtrW+1)'(pmfg_pkg::QDepth));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end
endmodule

>>> hw/rtl/pmfg_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module pmfg_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [pmfg_pkg::SumW-1:0] radicand,
	input  pmfg_pkg::pmfg_item_t item_in,
	output logic out_valid,
	output logic [pmfg_pkg::LenW-1:0] root,
	output pmfg_pkg::pmfg_item_t item_out
);
	localparam int NS = pmfg_pkg::LenW;
	logic v_q [NS];
	logic [pmfg_pkg::SumW-1:0] rad_q [NS];
	logic [pmfg_pkg::LenW+1:0] rem_q [NS];
	logic [pmfg_pkg::LenW-1:0] root_q [NS];
	pmfg_pkg::pmfg_item_t item_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic v_i;
		logic [pmfg_pkg::SumW-1:0] rad_i;
		logic [pmfg_pkg::LenW+1:0] rem_i;
		logic [pmfg_pkg::LenW-1:0] root_i;
		pmfg_pkg::pmfg_item_t item_i;
		logic [pmfg_pkg::LenW+3:0] t;
		logic [pmfg_pkg::LenW+3:0] trial;
		if (k == 0) begin : g_first
			assign v_i = in_valid;
			assign rad_i = radicand;
			assign rem_i = '0;
			assign root_i = '0;
			assign item_i = item_in;
		end else begin : g_next
			assign v_i = v_q[k-1];
			assign rad_i = rad_q[k-1];
			assign rem_i = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign item_i = item_q[k-1];
		end
		assign t = {rem_i, rad_i[pmfg_pkg::SumW-1 -: 2]};
		assign trial = {2'b00, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= {rad_i[pmfg_pkg::SumW-3:0], 2'b00};
				item_q[k] <= item_i;
				if (t >= trial) begin
					rem_q[k] <= (pmfg_pkg::LenW+2)'(t - trial);
					root_q[k] <= {root_i[pmfg_pkg::LenW-2:0], 1'b1};
				end else begin
					rem_q[k] <= t[pmfg_pkg::LenW+1:0];
					root_q[k] <= {root_i[pmfg_pkg::LenW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[NS-1];
	assign root = root_q[NS-1];
	assign item_out = item_q[NS-1];
endmodule

>>> hw/rtl/pmfg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module pmfg_div (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [pmfg_pkg::NumW-1:0] num,
	input  logic [pmfg_pkg::LenW-1:0] den,
	input  pmfg_pkg::pmfg_side_t side_in,
	output logic out_valid,
	output logic [pmfg_pkg::NumW-1:0] quo,
	output pmfg_pkg::pmfg_side_t side_out
);
	localparam int NS = pmfg_pkg::NumW;
	logic v_q [NS];
	logic [pmfg_pkg::NumW-1:0] nq_q [NS];
	logic [pmfg_pkg::LenW-1:0] rem_q [NS];
	logic [pmfg_pkg::LenW-1:0] den_q [NS];
	pmfg_pkg::pmfg_side_t side_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic v_i;
		logic [pmfg_pkg::NumW-1:0] nq_i;
		logic [pmfg_pkg::LenW-1:0] rem_i;
		logic [pmfg_pkg::LenW-1:0] den_i;
		pmfg_pkg::pmfg_side_t side_i;
		logic [pmfg_pkg::LenW:0] t;
		if (k == 0) begin : g_first
			assign v_i = in_valid;
			assign nq_i = num;
			assign rem_i = '0;
			assign den_i = den;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i = v_q[k-1];
			assign nq_i = nq_q[k-1];
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
			assign side_i = side_q[k-1];
		end
		assign t = {rem_i, nq_i[pmfg_pkg::NumW-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= den_i;
				side_q[k] <= side_i;
				if (t >= {1'b0, den_i}) begin
					rem_q[k] <= pmfg_pkg::LenW'(t - {1'b0, den_i});
					nq_q[k] <= {nq_i[pmfg_pkg::NumW-2:0], 1'b1};
				end else begin
					rem_q[k] <= t[pmfg_pkg::LenW-1:0];
					nq_q[k] <= {nq_i[pmfg_pkg::NumW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[NS-1];
	assign quo = nq_q[NS-1];
	assign side_out = side_q[NS-1];
endmodule

>>> hw/rtl/pmfg_back.sv
// Arithmetic pipeline: length, force factor, scaled and saturated components.
module pmfg_back (
	input  logic clk,
	input  logic arst_n,
	input  pmfg_pkg::pmfg_cfg_t cfg,
	input  pmfg_pkg::pmfg_qstat_t q_stat,
	input  pmfg_pkg::pmfg_item_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0][31:0] force_out,
	output logic applied
);
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pmfg_pkg::pmfg_item_t item_s1, item_s2;
	logic [2:0][65:0] sq_s1;
	logic [pmfg_pkg::SumW-1:0] sum_s2;
	logic sq_valid;
	logic [pmfg_pkg::LenW-1:0] len;
	pmfg_pkg::pmfg_item_t sq_item;
	pmfg_pkg::pmfg_side_t side_s3, side_s4, side_s5, side_s6;
	logic [pmfg_pkg::NumW-1:0] num_s3;
	logic [pmfg_pkg::LenW-1:0] den_s3;
	logic d_valid;
	logic [pmfg_pkg::NumW-1:0] quo;
	pmfg_pkg::pmfg_side_t d_side;
	logic [56:0] plo_s4;
	logic [55:0] phi_s4;
	logic [pmfg_pkg::FacW-1:0] fd_s4;
	logic [pmfg_pkg::FacW-1:0] fac_s5;
	logic [2:0][56:0] lo_s6;
	logic [2:0][56:0] hi_s6;
	logic out_valid_q;
	logic applied_q;
	logic [2:0][31:0] force_q;
	logic zero_c;
	logic [pmfg_pkg::LenW-1:0] diff_c;
	logic [pmfg_pkg::LenW-1:0] rest_c;
	logic [pmfg_pkg::LenW-1:0] k_c;
	logic [pmfg_pkg::FacW-1:0] fd_c;
	logic [pmfg_pkg::FacW-1:0] fac_c;
	logic [2:0][31:0] force_c;

	assign en = !out_valid_q || !out_stall;
	assign pop = en && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_stat.empty;
			v_s2 <= v_s1;
			v_s3 <= sq_valid;
			v_s4 <= d_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= {33'd0, head.mag[i]} * {33'd0, head.mag[i]};
			end
			item_s2 <= item_s1;
			sum_s2 <= pmfg_pkg::SumW'(sq_s1[0]) + pmfg_pkg::SumW'(sq_s1[1])
				+ pmfg_pkg::SumW'(sq_s1[2]);
		end
	end

	pmfg_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2), .radicand(sum_s2),
		.item_in(item_s2), .out_valid(sq_valid), .root(len), .item_out(sq_item)
	);

	always_comb begin
		if (sq_item.op == pmfg_pkg::OP_SPRING) begin
			rest_c = pmfg_pkg::LenW'(cfg.spr_rest);
			k_c = pmfg_pkg::LenW'(cfg.spr_k);
		end else begin
			rest_c = pmfg_pkg::LenW'(cfg.bng_rest);
			k_c = pmfg_pkg::LenW'(cfg.bng_k);
		end
		diff_c = (len > rest_c) ? len - rest_c : rest_c - len;
		zero_c = (sq_item.op == pmfg_pkg::OP_NONE)
			|| ((sq_item.op != pmfg_pkg::OP_DRAG) && ((len == '0)
			|| ((sq_item.op == pmfg_pkg::OP_BUNGEE) && ((len <= rest_c) || (k_c == '0)))));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.item <= sq_item;
			side_s3.zero <= zero_c;
			side_s3.dprod <= 66'(cfg.drag_quad) * 66'(len);
			num_s3 <= {diff_c, 16'd0};
			den_s3 <= len;
		end
	end

	pmfg_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3), .num(num_s3), .den(den_s3),
		.side_in(side_s3), .out_valid(d_valid), .quo(quo), .side_out(d_side)
	);

	always_comb begin
		logic [50:0] sd;
		sd = 51'(d_side.dprod[65:16]) + 51'(cfg.drag_lin);
		fd_c = (sd >= 51'(pmfg_pkg::FacCap)) ? pmfg_pkg::FacCap : sd[pmfg_pkg::FacW-1:0];
	end

	always_ff @(posedge clk) begin
		logic [pmfg_pkg::CfgW-1:0] kk;
		if (en) begin
			kk = (d_side.item.op == pmfg_pkg::OP_SPRING) ? cfg.spr_k : cfg.bng_k;
			side_s4 <= d_side;
			plo_s4 <= 57'(kk) * 57'(quo[25:0]);
			phi_s4 <= 56'(kk) * 56'(quo[50:26]);
			fd_s4 <= fd_c;
		end
	end

	always_comb begin
		logic [81:0] kp;
		kp = {phi_s4, 26'd0} + 82'(plo_s4);
		if (side_s4.item.op == pmfg_pkg::OP_DRAG) begin
			fac_c = fd_s4;
		end else if (kp[81:16] >= 66'(pmfg_pkg::FacCap)) begin
			fac_c = pmfg_pkg::FacCap;
		end else begin
			fac_c = kp[16 +: pmfg_pkg::FacW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			fac_s5 <= fac_c;
			side_s6 <= side_s5;
			for (int i = 0; i < 3; i++) begin
				lo_s6[i] <= 57'(side_s5.item.mag[i]) * 57'(fac_s5[23:0]);
				hi_s6[i] <= 57'(side_s5.item.mag[i]) * 57'(fac_s5[47:24]);
			end
		end
	end

	always_comb begin
		logic [80:0] p;
		logic [64:0] v;
		for (int i = 0; i < 3; i++) begin
			p = {hi_s6[i], 24'd0} + 81'(lo_s6[i]);
			v = p[80:16];
			if (side_s6.zero) begin
				force_c[i] = 32'd0;
			end else if (side_s6.item.pos[i]) begin
				force_c[i] = (v >= 65'h0_8000_0000) ? 32'h8000_0000 : 32'(0 - v[31:0]);
			end else begin
				force_c[i] = (v >= 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_q <= force_c;
			applied_q <= !side_s6.zero;
		end
	end

	assign out_valid = out_valid_q;
	assign force_out = force_q;
	assign applied = applied_q;
endmodule

>>> hw/rtl/point_mass_force_generator.sv
// Top level of the point mass force generator: registers, front end, queue, pipeline.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   operation, a_x..a_z, b_x..b_z
//   out      output     out_valid/out_stall force_x, force_y, force_z, applied
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item enters per cycle and one result leaves per cycle while out_stall stays low;
// each item passes through the 35-stage square root and the 51-stage divider.
// Reset loads the register defaults at once; there is no clearing pass.
// A stalled output freezes the pipeline; the four-entry queue then fills and raises in_stall.
`include "point_mass_force_generator_assert.svh"
module point_mass_force_generator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic applied,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	pmfg_pkg::pmfg_cfg_t cfg_q;
	pmfg_pkg::pmfg_qstat_t q_st;
	pmfg_pkg::pmfg_item_t f_item;
	pmfg_pkg::pmfg_item_t q_head;
	logic f_valid;
	logic q_pop;
	logic [2:0][31:0] force_v;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drag_lin <= '0;
			cfg_q.drag_quad <= '0;
			cfg_q.spr_k <= '0;
			cfg_q.spr_rest <= 31'd65536;
			cfg_q.bng_k <= '0;
			cfg_q.bng_rest <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pmfg_pkg::reg_idx_t'(cfg_index))
				pmfg_pkg::REG_DRAG_LIN: cfg_q.drag_lin <= cfg_data[30:0];
				pmfg_pkg::REG_DRAG_QUAD: cfg_q.drag_quad <= cfg_data[30:0];
				pmfg_pkg::REG_SPR_K: cfg_q.spr_k <= cfg_data[30:0];
				pmfg_pkg::REG_SPR_REST: cfg_q.spr_rest <= cfg_data[30:0];
				pmfg_pkg::REG_BNG_K: cfg_q.bng_k <= cfg_data[30:0];
				pmfg_pkg::REG_BNG_REST: cfg_q.bng_rest <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	pmfg_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .q_full(q_st.full),
		.item_valid(f_valid), .item(f_item)
	);

	pmfg_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .push_item(f_item),
		.pop(q_pop), .head(q_head), .stat(q_st)
	);

	pmfg_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_stat(q_st), .head(q_head),
		.pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
		.force_out(force_v), .applied(applied)
	);

	assign force_x = force_v[0];
	assign force_y = force_v[1];
	assign force_z = force_v[2];

	`PMFG_ASSERT_IMP(a_slack_zero, out_valid && !applied, force_v == '0)
	`PMFG_ASSERT_NXT(a_full_holds, q_st.full && !q_pop, q_st.full)
	`PMFG_ASSERT_IMP(a_stall_full, in_stall, q_st.full && !q_st.empty)
endmodule

>>> test/point_mass_force_generator_test.sv
// Testbench of the point mass force generator: random and directed forces and a scoreboard.
module point_mass_force_generator_test;
	localparam int MaxCycles = 300000;
	localparam logic [63:0] ProdCap = 64'h0001_0000_0000_0000;

	typedef struct {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic ap;
	} force_t;

	class force_book;
		force_t pending[$];
		logic [30:0] regs[6];
		int errors;

		function new();
			errors = 0;
			regs = '{0, 0, 0, 65536, 0, 65536};
		endfunction

		function logic [63:0] qmul(logic [63:0] x, logic [63:0] y);
			logic [127:0] p;
			p = {64'b0, x} * {64'b0, y};
			p = p >> 16;
			if (p > {64'b0, ProdCap})
				return ProdCap;
			return p[63:0];
		endfunction

		function logic [31:0] clamp(logic [63:0] m, logic neg);
			logic [31:0] r;
			if (neg) begin
				r = m >= 64'h8000_0000 ? 32'h8000_0000 : -m[31:0];
			end else begin
				r = m >= 64'h7FFF_FFFF ? 32'h7FFF_FFFF : m[31:0];
			end
			return r;
		endfunction

		function force_t compute(pmfg_pkg::op_t op, logic signed [31:0] a[3],
				logic signed [31:0] b[3]);
			force_t f;
			logic signed [32:0] w[3];
			logic [32:0] m[3];
			logic [71:0] sq, cc;
			logic [63:0] len, c, fac, k, rest, diff;
			f = '{0, 0, 0, 1'b0};
			if (op == pmfg_pkg::OP_NONE)
				return f;
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				w[i] = (op == pmfg_pkg::OP_DRAG) ? {a[i][31], a[i]}
					: {a[i][31], a[i]} - {b[i][31], b[i]};
				m[i] = w[i][32] ? -w[i] : w[i];
				sq += {39'b0, m[i]} * {39'b0, m[i]};
			end
			len = 0;
			for (int i = 34; i >= 0; i--) begin
				c = len | (64'd1 << i);
				cc = {8'b0, c};
				if (cc * cc <= sq)
					len = c;
			end
			if (op == pmfg_pkg::OP_DRAG) begin
				fac = regs[pmfg_pkg::REG_DRAG_LIN]
					+ qmul(regs[pmfg_pkg::REG_DRAG_QUAD], len);
			end else begin
				k = (op == pmfg_pkg::OP_SPRING) ? regs[pmfg_pkg::REG_SPR_K]
					: regs[pmfg_pkg::REG_BNG_K];
				rest = (op == pmfg_pkg::OP_SPRING) ? regs[pmfg_pkg::REG_SPR_REST]
					: regs[pmfg_pkg::REG_BNG_REST];
				if (len == 0)
					return f;
				if (op == pmfg_pkg::OP_BUNGEE && (len <= rest || k == 0))
					return f;
				diff = len > rest ? len - rest : rest - len;
				fac = qmul(k, (diff << 16) / len);
			end
			f.fx = clamp(qmul(m[0], fac), w[0] > 0);
			f.fy = clamp(qmul(m[1], fac), w[1] > 0);
			f.fz = clamp(qmul(m[2], fac), w[2] > 0);
			f.ap = 1'b1;
			return f;
		endfunction

		function void note_input(pmfg_pkg::op_t op, logic signed [31:0] a[3],
				logic signed [31:0] b[3]);
			pending = {pending, compute(op, a, b)};
		endfunction

		function void check_result(force_t got);
			force_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %b", $time, got.fx, got.fy, got.fz,
					got.ap);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.fx !== want.fx) begin
				$display("%0t: force_x expected %h actual %h", $time, want.fx, got.fx);
				errors++;
			end
			if (got.fy !== want.fy) begin
				$display("%0t: force_y expected %h actual %h", $time, want.fy, got.fy);
				errors++;
			end
			if (got.fz !== want.fz) begin
				$display("%0t: force_z expected %h actual %h", $time, want.fz, got.fz);
				errors++;
			end
			if (got.ap !== want.ap) begin
				$display("%0t: applied expected %b actual %b", $time, want.ap, got.ap);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] force_x, force_y, force_z;
	logic applied;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	force_book book = new();
	int cycles = 0;
	bit no_idle = 0;
	int rx_hold = 0;

	point_mass_force_generator u_top (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		logic signed [31:0] a[3], b[3];
		cycles++;
		if (cycles > MaxCycles) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && in_valid && !in_stall) begin
			a = '{a_x, a_y, a_z};
			b = '{b_x, b_y, b_z};
			book.note_input(pmfg_pkg::op_t'(operation), a, b);
		end
		if (arst_n && out_valid && !out_stall)
			book.check_result('{force_x, force_y, force_z, applied});
	end

	// The receiver stalls per result, or for a long stretch on request.
	initial begin
		int n;
		bit took;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 3);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			do begin
				#1 took = out_valid;
				if (!took)
					@(negedge clk);
			end while (!took);
		end
	end

	task automatic write_reg(pmfg_pkg::reg_idx_t idx, logic [31:0] data);
		bit ok;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			#1 ok = cfg_ready;
			@(negedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		book.regs[idx] = data[30:0];
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_force(pmfg_pkg::op_t op, logic signed [31:0] a[3],
			logic signed [31:0] b[3]);
		int gap;
		bit ok;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		{a_x, a_y, a_z} <= {a[0], a[1], a[2]};
		{b_x, b_y, b_z} <= {b[0], b[1], b[2]};
		do begin
			#1 ok = !in_stall;
			@(negedge clk);
		end while (!ok);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (book.pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_reg();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return {1'b0, 31'h7FFF_FFFF} | ($urandom & 32'h8000_0000);
			2: return $urandom;
			default: return $urandom_range(0, 32'h0008_0000);
		endcase
	endfunction

	task automatic send_random();
		logic signed [31:0] a[3], b[3];
		pmfg_pkg::op_t op;
		op = pmfg_pkg::op_t'($urandom_range(0, 7) == 0 ? 3 : $urandom_range(0, 2));
		for (int i = 0; i < 3; i++) begin
			a[i] = pick_value();
			// Ends near each other keep spring lengths close to the rest length.
			b[i] = $urandom_range(0, 1) ? a[i] + $urandom_range(0, 32'h0003_0000)
				- 32'h0001_8000 : pick_value();
		end
		send_force(op, a, b);
	endtask

	initial begin
		logic signed [31:0] a[3], b[3];
		logic signed [31:0] ext[4];
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h0001_0000};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings, then every register set.
		a = '{32'h0002_0000, 0, 0};
		b = '{0, 0, 0};
		send_force(pmfg_pkg::OP_SPRING, a, b);
		send_force(pmfg_pkg::OP_BUNGEE, a, b);
		drain();
		write_reg(pmfg_pkg::REG_DRAG_LIN, 32'h0000_8000);
		write_reg(pmfg_pkg::REG_DRAG_QUAD, 32'h0000_4000);
		write_reg(pmfg_pkg::REG_SPR_K, 32'h0003_0000);
		write_reg(pmfg_pkg::REG_SPR_REST, 32'h0002_0000);
		write_reg(pmfg_pkg::REG_BNG_K, 32'h0002_0000);
		write_reg(pmfg_pkg::REG_BNG_REST, 32'h0003_0000);
		for (int i = 0; i < 4; i++) begin
			a = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]};
			b = '{ext[(i + 3) % 4], ext[i], ext[(i + 1) % 4]};
			send_force(pmfg_pkg::OP_DRAG, a, b);
			send_force(pmfg_pkg::OP_SPRING, a, b);
			send_force(pmfg_pkg::OP_BUNGEE, a, b);
			send_force(pmfg_pkg::OP_NONE, a, b);
		end
		a = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
		send_force(pmfg_pkg::OP_SPRING, a, a);
		send_force(pmfg_pkg::OP_BUNGEE, a, a);
		b = '{32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000};
		send_force(pmfg_pkg::OP_BUNGEE, a, b);
		b = '{32'h0009_0000, 32'hFFFF_0000, 32'h0000_8000};
		send_force(pmfg_pkg::OP_BUNGEE, a, b);
		send_force(pmfg_pkg::OP_SPRING, a, b);
		drain();
		write_reg(pmfg_pkg::REG_BNG_K, 0);
		send_force(pmfg_pkg::OP_BUNGEE, a, b);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			for (int r = 0; r < 6; r++) begin
				if (phase == 0)
					write_reg(pmfg_pkg::reg_idx_t'(r), 32'hFFFF_FFFF);
				else if (phase == 1)
					write_reg(pmfg_pkg::reg_idx_t'(r), 0);
				else
					write_reg(pmfg_pkg::reg_idx_t'(r), pick_reg());
			end
			no_idle = (phase % 3 == 2);
			if (phase == 4)
				rx_hold = 400;
			for (int n = 0; n < 105; n++)
				send_random();
			drain();
		end

		if (book.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

>>> point_mass_force_generator.f
+incdir+hw/rtl
hw/rtl/pmfg_pkg.sv
hw/rtl/pmfg_front.sv
hw/rtl/pmfg_queue.sv
hw/rtl/pmfg_sqrt.sv
hw/rtl/pmfg_div.sv
hw/rtl/pmfg_back.sv
hw/rtl/point_mass_force_generator.sv
test/point_mass_force_generator_test.sv
